@@ hdl/led_flash_sequence_player_macros.svh @@
// Assertion shorthands for the LED flash sequence player checker.
`ifndef LED_FLASH_SEQUENCE_PLAYER_MACROS_SVH
`define LED_FLASH_SEQUENCE_PLAYER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LFSP_AST_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define LFSP_AST_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lfsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfsp_pkg;

	// Parameter defaults
	localparam int DEF_MAX_ENTRIES = 8;
	localparam int DEF_LED_COUNT   = 8;

	// Fixed field widths
	localparam int TIME_W    = 8;
	localparam int CODES_W   = 32;
	localparam int SEQ_LEN_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	// Item operations
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	// Play phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ON     = 2'd1;
	localparam logic [1:0] PH_OFF    = 2'd2;
	localparam logic [1:0] PH_REPEAT = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WAIT = 1'd1;

	typedef struct packed {
		logic [1:0]         op;
		logic [2:0]         entry_index;
		logic [TIME_W-1:0]  on_ticks;
		logic [TIME_W-1:0]  off_ticks;
		logic [TIME_W-1:0]  flash_count;
		logic [CODES_W-1:0] led_codes;
	} item_t;

	typedef struct packed {
		logic [CODES_W-1:0] led_codes;
		logic               leds_dark;
		logic [1:0]         phase;
		logic [2:0]         entry_now;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/lfsp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [AW-1:0]            raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/lfsp_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfsp_seq import lfsp_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int LED_COUNT   = DEF_LED_COUNT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_take,
	input  wire item_t                item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_DAT_W-1:0] cfg_dat,
	output logic                      res_push,
	output res_t                      res
);

	localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LIT_LEDS = (LED_COUNT < 8) ? LED_COUNT : 8;
	localparam int CODE_W   = 4 * LIT_LEDS;
	localparam int SLOT_W   = CODE_W + 3 * TIME_W;
	localparam int CNT_W    = (IDX_W + 1 > SEQ_LEN_W) ? IDX_W + 1 : SEQ_LEN_W;
	localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_ENTRIES);

	// Slot layout: codes | on | off | flashes
	localparam int ON_LSB  = 2 * TIME_W;
	localparam int OFF_LSB = TIME_W;

	logic [1:0]        phase_q, phase_d;
	logic [IDX_W-1:0]  entry_q, entry_d;
	logic [TIME_W-1:0] flashes_q, flashes_d;
	logic [TIME_W-1:0] ticks_q, ticks_d;
	logic [SEQ_LEN_W-1:0] seq_len_q;
	logic [TIME_W-1:0] rep_wait_q;
	logic [TIME_W-1:0] head_on_q;
	logic [CODE_W-1:0] head_codes_q;

	logic [SLOT_W-1:0] cur_slot, nxt_slot, wr_slot;
	logic [IDX_W-1:0]  wr_addr, nxt_addr;
	logic              wr_en;

	logic [CODE_W-1:0] cur_codes, nxt_codes;
	logic [TIME_W-1:0] cur_on, cur_off, cur_flashes, nxt_on;

	logic [CNT_W-1:0]  lim, n_ent;
	logic [TIME_W-1:0] fd;
	logic              fl_done, wrap, do_flash;
	logic              show_v, emit_v, emit_dark;
	logic [TIME_W-1:0] show_on;
	logic [CODE_W-1:0] show_codes;

	// Table copies: one read at the current entry, one at the entry after it.
	// Both read with the next-state entry so data lines up with the next item.
	assign nxt_addr = IDX_W'(entry_d + 1'b1);

	lfsp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_ram_cur (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_slot),
		.raddr (entry_d),
		.rdata (cur_slot)
	);

	lfsp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_ram_nxt (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_slot),
		.raddr (nxt_addr),
		.rdata (nxt_slot)
	);

	assign cur_codes   = cur_slot[SLOT_W-1 -: CODE_W];
	assign cur_on      = cur_slot[ON_LSB +: TIME_W];
	assign cur_off     = cur_slot[OFF_LSB +: TIME_W];
	assign cur_flashes = cur_slot[TIME_W-1:0];
	assign nxt_codes   = nxt_slot[SLOT_W-1 -: CODE_W];
	assign nxt_on      = nxt_slot[ON_LSB +: TIME_W];

	// Table write
	assign wr_en   = item_take && (item.op == OP_WRITE) &&
	                 ({29'd0, item.entry_index} < 32'(MAX_ENTRIES));
	assign wr_addr = IDX_W'(item.entry_index);
	assign wr_slot = {item.led_codes[CODE_W-1:0], item.on_ticks,
	                  item.off_ticks, item.flash_count};

	// End-of-flash bookkeeping
	assign lim     = (CNT_W'(seq_len_q) > LIMIT_MAX) ? LIMIT_MAX : CNT_W'(seq_len_q);
	assign fd      = flashes_q + 1'b1;
	assign fl_done = (fd == cur_flashes);
	assign n_ent   = fl_done ? CNT_W'(entry_q) + 1'b1 : CNT_W'(entry_q);
	assign wrap    = (n_ent >= lim);

	// Next state and result
	always_comb begin
		phase_d    = phase_q;
		entry_d    = entry_q;
		flashes_d  = flashes_q;
		ticks_d    = ticks_q;
		do_flash   = 1'b0;
		show_v     = 1'b0;
		show_on    = head_on_q;
		show_codes = head_codes_q;
		emit_v     = 1'b0;
		emit_dark  = 1'b0;

		if (item_take) begin
			case (item.op)
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (ticks_q > 8'd1) begin
							ticks_d = ticks_q - 1'b1;
						end else begin
							ticks_d = '0;
							case (phase_q)
								PH_ON: begin
									if (cur_off == '0) begin
										do_flash = 1'b1;
									end else begin
										phase_d   = PH_OFF;
										ticks_d   = cur_off;
										emit_v    = 1'b1;
										emit_dark = 1'b1;
									end
								end
								PH_OFF: begin
									do_flash = 1'b1;
								end
								PH_REPEAT: begin
									show_v     = 1'b1;
									show_on    = cur_on;
									show_codes = cur_codes;
								end
								default: ;
							endcase
						end
					end
				end
				OP_START: begin
					entry_d   = '0;
					flashes_d = '0;
					show_v    = 1'b1;
				end
				OP_STOP: begin
					phase_d   = PH_IDLE;
					ticks_d   = '0;
					emit_v    = 1'b1;
					emit_dark = 1'b1;
				end
				default: begin
					// write item: a playing sequence stops first
					if (phase_q != PH_IDLE) begin
						phase_d   = PH_IDLE;
						ticks_d   = '0;
						emit_v    = 1'b1;
						emit_dark = 1'b1;
					end
				end
			endcase
		end

		// Flash finished: same entry again, next entry, or loop
		if (do_flash) begin
			flashes_d = fl_done ? '0 : fd;
			if (wrap) begin
				entry_d = '0;
				if (rep_wait_q != '0) begin
					ticks_d = rep_wait_q;
					phase_d = PH_REPEAT;
				end else begin
					show_v = 1'b1;
				end
			end else begin
				entry_d    = IDX_W'(n_ent);
				show_v     = 1'b1;
				show_on    = fl_done ? nxt_on : cur_on;
				show_codes = fl_done ? nxt_codes : cur_codes;
			end
		end

		// Light an entry
		if (show_v) begin
			phase_d   = PH_ON;
			ticks_d   = (show_on == '0) ? 8'd1 : show_on;
			emit_v    = 1'b1;
			emit_dark = 1'b0;
		end
	end

	assign res_push      = emit_v;
	assign res.led_codes = emit_dark ? '0 : CODES_W'(show_codes);
	assign res.leds_dark = emit_dark;
	assign res.phase     = phase_d;
	assign res.entry_now = 3'(entry_d);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			entry_q    <= '0;
			flashes_q  <= '0;
			ticks_q    <= '0;
			seq_len_q  <= '0;
			rep_wait_q <= '0;
		end else begin
			phase_q   <= phase_d;
			entry_q   <= entry_d;
			flashes_q <= flashes_d;
			ticks_q   <= ticks_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SEQ_LEN:     seq_len_q  <= cfg_dat[SEQ_LEN_W-1:0];
					CFG_REPEAT_WAIT: rep_wait_q <= cfg_dat;
					default: ;
				endcase
			end
		end
	end

	// Entry 0 kept at hand for start and loop
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			head_on_q    <= item.on_ticks;
			head_codes_q <= item.led_codes[CODE_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hdl/lfsp_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfsp_obuf import lfsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t din,
	input  wire logic stall,
	output logic      valid,
	output res_t      dout,
	output logic      full
);

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic take;

	assign take  = main_v_q && !stall;
	assign valid = main_v_q;
	assign dout  = main_q;
	assign full  = skid_v_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (!push) begin
				main_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= din;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_q <= din;
			end else begin
				skid_q <= din;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/led_flash_sequence_player.sv @@
// LED flash sequence player. Plays a table of up to MAX_ENTRIES patterns, each
// with LED codes, an on time, an off time and a flash count, advancing on tick
// items; start, stop and table-write items share the same channel. One item is
// taken every clock cycle while item_stall is low, and its LED update, if any,
// is offered from an output register. The pattern table sits in two copies of a
// small RAM with a registered read, addressed with the entry the player will
// hold after the current cycle, so the read latency is hidden and no item waits
// on it. Two output registers hold updates; item_stall is high while both are
// full, which only a stalled output side can cause, and drops the cycle after
// an update leaves. The table needs no clearing pass: an entry must be written
// before it is played. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module led_flash_sequence_player import lfsp_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int LED_COUNT   = DEF_LED_COUNT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [1:0]           op,
	input  wire logic [2:0]           entry_index,
	input  wire logic [TIME_W-1:0]    entry_on_ticks,
	input  wire logic [TIME_W-1:0]    entry_off_ticks,
	input  wire logic [TIME_W-1:0]    entry_flash_count,
	input  wire logic [CODES_W-1:0]   entry_led_codes,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [CODES_W-1:0]        led_codes,
	output logic                      leds_dark,
	output logic [1:0]                phase,
	output logic [2:0]                entry_now,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	item_t item;
	res_t  res, res_out;
	logic  item_take, res_push, buf_full;

	assign item.op          = op;
	assign item.entry_index = entry_index;
	assign item.on_ticks    = entry_on_ticks;
	assign item.off_ticks   = entry_off_ticks;
	assign item.flash_count = entry_flash_count;
	assign item.led_codes   = entry_led_codes;

	assign item_stall = buf_full;
	assign item_take  = item_valid && !buf_full;
	assign cfg_ready  = 1'b1;

	lfsp_seq #(.MAX_ENTRIES(MAX_ENTRIES), .LED_COUNT(LED_COUNT)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_take (item_take),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_dat   (cfg_data),
		.res_push  (res_push),
		.res       (res)
	);

	lfsp_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.stall  (result_stall),
		.valid  (result_valid),
		.dout   (res_out),
		.full   (buf_full)
	);

	assign led_codes = res_out.led_codes;
	assign leds_dark = res_out.leds_dark;
	assign phase     = res_out.phase;
	assign entry_now = res_out.entry_now;

endmodule

`default_nettype wire

@@ hdl/lfsp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "led_flash_sequence_player_macros.svh"

module lfsp_checker import lfsp_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_stall,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [CODES_W-1:0] led_codes,
	input wire logic               leds_dark,
	input wire logic [1:0]         phase
);

	// A stalled result stays offered
	`LFSP_AST_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid, "result dropped while stalled")

	// LEDs are dark exactly in the idle and off phases
	`LFSP_AST_IMP(a_dark_phase, clk, arst_n, result_valid, leds_dark == (phase == PH_IDLE || phase == PH_OFF), "dark flag does not match phase")

	// Dark updates carry no codes
	`LFSP_AST_IMP(a_dark_codes, clk, arst_n, result_valid && leds_dark, led_codes == '0, "codes shown while dark")

	// Entering the repeat wait rewrites no LEDs
	`LFSP_AST_IMP(a_no_repeat, clk, arst_n, result_valid, phase != PH_REPEAT, "update reported in repeat wait")

	// Input backs up only behind a stalled result
	`LFSP_AST_NXT(a_stall_cause, clk, arst_n, !(result_valid && result_stall), !item_stall, "item stall without output backpressure")

endmodule

bind led_flash_sequence_player lfsp_checker u_lfsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.led_codes    (led_codes),
	.leds_dark    (leds_dark),
	.phase        (phase)
);

`default_nettype wire
